// ===== design/assert_macros.svh =====
// assertion macros shared by the window resize geometry rtl
// expects clk and rst_n (active low) in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WRG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WRG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WRG_ASSERT_IMP(label, ante, cons, msg)
`define WRG_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== design/wrg_pkg.sv =====
// package for the window resize geometry block
// widths, operation and edge codes, register indexes and extension helpers; no dependencies
package wrg_pkg;

  localparam int COORD_W = 16;  // signed coordinates and result fields
  localparam int SIZE_W  = 15;  // unsigned window sizes and registers
  localparam int CALC_W  = 20;  // internal arithmetic, wide enough for every sum
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SIZE_W-1:0]  size_t;
  typedef logic signed [CALC_W-1:0]  calc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef enum logic [2:0] {
    OP_BEGIN    = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_COMMIT   = 3'd2,
    OP_MAXIMIZE = 3'd3,
    OP_RESTORE  = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    EDGE_L  = 3'd0,
    EDGE_R  = 3'd1,
    EDGE_T  = 3'd2,
    EDGE_B  = 3'd3,
    EDGE_TL = 3'd4,
    EDGE_TR = 3'd5,
    EDGE_BL = 3'd6,
    EDGE_BR = 3'd7
  } edge_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAB_ZONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DESK_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DESK_H    = 3'd4;

  localparam size_t MIN_SIZE_RST  = SIZE_W'(32);
  localparam size_t HEADER_H_RST  = SIZE_W'(24);
  localparam size_t GRAB_ZONE_RST = SIZE_W'(8);
  localparam size_t DESK_W_RST    = SIZE_W'(1920);
  localparam size_t DESK_H_RST    = SIZE_W'(1080);

  // sign extend a coordinate
  function automatic calc_t ext_c(coord_t v);
    return calc_t'(v);
  endfunction

  // zero extend a size or register value
  function automatic calc_t ext_s(size_t v);
    return calc_t'({1'b0, v});
  endfunction

  // zero extend a size into a coordinate field
  function automatic coord_t size_to_coord(size_t v);
    return coord_t'({1'b0, v});
  endfunction

endpackage

// ===== design/window_resize_geometry_top.sv =====
// window resize geometry engine: begin, update, commit, maximize, restore, clear
// depends on wrg_pkg and assert_macros.svh
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------------
//  in_     | input     | in_valid / in_ready  | opcode, win_x/y/w/h, pointer_x/y
//  out_    | output    | out_valid/out_ready  | x, y, w, h, grab_edge, ok, drag_active
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_index (register number), cfg_data
//
//  an accepted beat lands in the input register, then combinational logic computes the
//  result and the next state and loads the output register, one beat per cycle sustained
//  while the output is not stalled. the critical path is the update chain
//  (edge distance, min and desktop clamps, re-anchor, position clamp) at 20 bits.
//  rst_n is synchronous; it clears the drag and the stored rectangles and returns the
//  registers to their reset values. a stalled output holds its beat; the input register
//  still takes a beat whenever it is empty or the output register is free or draining
//  in the same cycle.

`include "assert_macros.svh"

module window_resize_geometry_top (
  input  logic                    clk,
  input  logic                    rst_n,
  // item input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_opcode,
  input  wrg_pkg::coord_t         in_win_x,
  input  wrg_pkg::coord_t         in_win_y,
  input  wrg_pkg::size_t          in_win_w,
  input  wrg_pkg::size_t          in_win_h,
  input  wrg_pkg::coord_t         in_pointer_x,
  input  wrg_pkg::coord_t         in_pointer_y,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output wrg_pkg::coord_t         out_x,
  output wrg_pkg::coord_t         out_y,
  output wrg_pkg::coord_t         out_w,
  output wrg_pkg::coord_t         out_h,
  output logic [2:0]              out_grab_edge,
  output logic                    out_ok,
  output logic                    out_drag_active,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  wrg_pkg::size_t          cfg_data
);
  import wrg_pkg::*;

  // configuration registers
  size_t min_size_r, header_h_r, grab_zone_r, desk_w_r, desk_h_r;

  // input register stage
  logic   s1_valid_r;
  logic [2:0] s1_op_r;
  coord_t s1_wx_r, s1_wy_r, s1_px_r, s1_py_r;
  size_t  s1_ww_r, s1_wh_r;

  // block state
  logic  active_r, active_nxt;
  rect_t org_r, org_nxt;
  edge_t edge_r, edge_nxt;
  rect_t tgt_r, tgt_nxt;
  logic  sav_valid_r, sav_valid_nxt;
  rect_t sav_r, sav_nxt;

  // output register
  logic  out_valid_r;
  rect_t res_r, res_nxt;
  edge_t res_edge_r;
  logic  res_ok_r, res_ok_nxt;
  logic  res_active_r;

  logic  adv;
  rect_t win;

  // edge pick for begin
  calc_t pk_x0, pk_y0, pk_px, pk_py, pk_g, pk_hh;
  logic  pk_l, pk_r, pk_t, pk_b;
  edge_t pk_edge;

  // update geometry
  logic  e_left, e_right, e_top, e_bot;
  calc_t fx, fr, fy, fb, mn, dw, dh, hh, hlim;
  calc_t w0, w1, w2, h0, h1, h2, x0, y0, xlim, ylim, xc, yc;
  rect_t upd_rect;

  // ---------------------------------------------------------------- handshakes
  // the result register drains or is empty: the held beat moves on
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r <= in_opcode;
      s1_wx_r <= in_win_x;
      s1_wy_r <= in_win_y;
      s1_ww_r <= in_win_w;
      s1_wh_r <= in_win_h;
      s1_px_r <= in_pointer_x;
      s1_py_r <= in_pointer_y;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r  <= MIN_SIZE_RST;
      header_h_r  <= HEADER_H_RST;
      grab_zone_r <= GRAB_ZONE_RST;
      desk_w_r    <= DESK_W_RST;
      desk_h_r    <= DESK_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_SIZE:  min_size_r  <= cfg_data;
        CFG_HEADER_H:  header_h_r  <= cfg_data;
        CFG_GRAB_ZONE: grab_zone_r <= cfg_data;
        CFG_DESK_W:    desk_w_r    <= cfg_data;
        CFG_DESK_H:    desk_h_r    <= cfg_data;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- edge pick
  // the new window is the origin when the pointer is classified
  always_comb begin
    win.x = s1_wx_r;
    win.y = s1_wy_r;
    win.w = size_to_coord(s1_ww_r);
    win.h = size_to_coord(s1_wh_r);

    pk_x0 = ext_c(s1_wx_r);
    pk_y0 = ext_c(s1_wy_r);
    pk_px = ext_c(s1_px_r);
    pk_py = ext_c(s1_py_r);
    pk_g  = ext_s(grab_zone_r);
    pk_hh = ext_s(header_h_r);
    pk_l  = pk_px <  pk_x0 + pk_g;
    pk_r  = pk_px >= pk_x0 + ext_s(s1_ww_r) - pk_g;
    pk_t  = pk_py <  pk_y0 + pk_g;
    pk_b  = pk_py >= pk_y0 + ext_s(s1_wh_r) + pk_hh - pk_g;

    // corners first, then single edges; no zone hit falls to bottom-right
    if (pk_t && pk_l)      pk_edge = EDGE_TL;
    else if (pk_t && pk_r) pk_edge = EDGE_TR;
    else if (pk_b && pk_l) pk_edge = EDGE_BL;
    else if (pk_b && pk_r) pk_edge = EDGE_BR;
    else if (pk_l)         pk_edge = EDGE_L;
    else if (pk_r)         pk_edge = EDGE_R;
    else if (pk_t)         pk_edge = EDGE_T;
    else if (pk_b)         pk_edge = EDGE_B;
    else                   pk_edge = EDGE_BR;
  end

  // ---------------------------------------------------------------- drag update
  always_comb begin
    e_left  = (edge_r == EDGE_L) || (edge_r == EDGE_TL) || (edge_r == EDGE_BL);
    e_right = (edge_r == EDGE_R) || (edge_r == EDGE_TR) || (edge_r == EDGE_BR);
    e_top   = (edge_r == EDGE_T) || (edge_r == EDGE_TL) || (edge_r == EDGE_TR);
    e_bot   = (edge_r == EDGE_B) || (edge_r == EDGE_BL) || (edge_r == EDGE_BR);

    hh = ext_s(header_h_r);
    mn = ext_s(min_size_r);
    dw = ext_s(desk_w_r);
    dh = ext_s(desk_h_r);
    fx = ext_c(org_r.x);
    fy = ext_c(org_r.y);
    fr = fx + ext_c(org_r.w);
    fb = fy + ext_c(org_r.h) + hh;

    // size from the dragged edge
    if (e_left)       w0 = fr - ext_c(s1_px_r);
    else if (e_right) w0 = ext_c(s1_px_r) - fx;
    else              w0 = ext_c(org_r.w);
    if (e_top)        h0 = fb - ext_c(s1_py_r) - hh;
    else if (e_bot)   h0 = ext_c(s1_py_r) - fy - hh;
    else              h0 = ext_c(org_r.h);

    // minimum first, the desktop bound wins
    hlim = dh - hh;
    w1 = (w0 < mn) ? mn : w0;
    h1 = (h0 < mn) ? mn : h0;
    w2 = (w1 > dw) ? dw : w1;
    h2 = (h1 > hlim) ? hlim : h1;

    // keep the opposite edge fixed when dragging left or top
    x0 = e_left ? (fr - w2) : fx;
    y0 = e_top  ? (fb - h2 - hh) : fy;

    // position clamp, lower bound taken first when the bounds cross
    xlim = dw - w2;
    ylim = dh - h2 - hh;
    if (x0 < 0)         xc = '0;
    else if (x0 > xlim) xc = xlim;
    else                xc = x0;
    if (y0 < 0)         yc = '0;
    else if (y0 > ylim) yc = ylim;
    else                yc = y0;

    upd_rect.x = xc[COORD_W-1:0];
    upd_rect.y = yc[COORD_W-1:0];
    upd_rect.w = w2[COORD_W-1:0];
    upd_rect.h = h2[COORD_W-1:0];
  end

  // ---------------------------------------------------------------- operation
  always_comb begin
    active_nxt    = active_r;
    org_nxt       = org_r;
    edge_nxt      = edge_r;
    tgt_nxt       = tgt_r;
    sav_valid_nxt = sav_valid_r;
    sav_nxt       = sav_r;
    res_nxt       = '0;
    res_ok_nxt    = 1'b1;

    case (s1_op_r)
      OP_BEGIN: begin
        active_nxt = 1'b1;
        org_nxt    = win;
        tgt_nxt    = win;
        edge_nxt   = pk_edge;
        res_nxt    = win;
      end
      OP_UPDATE: begin
        // no drag: zero geometry, nothing changes
        if (active_r) begin
          tgt_nxt = upd_rect;
          res_nxt = upd_rect;
        end
      end
      OP_COMMIT: begin
        res_nxt    = tgt_r;
        active_nxt = 1'b0;
      end
      OP_MAXIMIZE: begin
        sav_valid_nxt = 1'b1;
        sav_nxt       = win;
        res_nxt.w     = size_to_coord(desk_w_r);
        res_nxt.h     = size_to_coord(desk_h_r) - size_to_coord(header_h_r);
      end
      OP_RESTORE: begin
        if (sav_valid_r) begin
          res_nxt       = sav_r;
          sav_valid_nxt = 1'b0;
        end else begin
          res_ok_nxt = 1'b0;
        end
      end
      OP_CLEAR: begin
        sav_valid_nxt = 1'b0;
      end
      default: ;  // unused codes: zero geometry, ok set
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      org_r       <= '0;
      edge_r      <= EDGE_L;
      tgt_r       <= '0;
      sav_valid_r <= 1'b0;
      sav_r       <= '0;
    end else if (adv) begin
      active_r    <= active_nxt;
      org_r       <= org_nxt;
      edge_r      <= edge_nxt;
      tgt_r       <= tgt_nxt;
      sav_valid_r <= sav_valid_nxt;
      sav_r       <= sav_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r        <= res_nxt;
      res_edge_r   <= edge_nxt;
      res_ok_r     <= res_ok_nxt;
      res_active_r <= active_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = res_r.x;
  assign out_y           = res_r.y;
  assign out_w           = res_r.w;
  assign out_h           = res_r.h;
  assign out_grab_edge   = res_edge_r;
  assign out_ok          = res_ok_r;
  assign out_drag_active = res_active_r;

  // ---------------------------------------------------------------- checks
  `WRG_ASSERT_NXT(a_begin_arms, adv && (s1_op_r == OP_BEGIN), active_r && out_drag_active, "begin did not start a drag")
  `WRG_ASSERT_NXT(a_commit_ends, adv && (s1_op_r == OP_COMMIT), !active_r && !out_drag_active, "commit left a drag active")
  `WRG_ASSERT_NXT(a_ok_only_restore, adv && (s1_op_r != OP_RESTORE), out_ok, "ok cleared outside restore")
  `WRG_ASSERT_NXT(a_idle_update, adv && (s1_op_r == OP_UPDATE) && !active_r, (out_w == '0) && (out_h == '0) && !out_drag_active, "update without drag gave geometry")
  `WRG_ASSERT_IMP(a_ready_when_empty, !s1_valid_r, in_ready, "input stage empty but not ready")

endmodule

// ===== tb/sv/window_resize_geometry_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for window_resize_geometry_top: drags, maximize/restore/clear and
// register settings, every result beat checked against an in-bench geometry predictor
// depends on wrg_pkg and the window_resize_geometry_top rtl
module window_resize_geometry_top_tb;
  import wrg_pkg::*;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int N_SETTINGS = 8;

  // one input beat, field order matches the port list
  typedef struct packed {
    logic [2:0] op;
    coord_t     wx;
    coord_t     wy;
    size_t      ww;
    size_t      wh;
    coord_t     px;
    coord_t     py;
  } cmd_t;

  // one result beat
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    edge_t  grab;
    logic   ok;
    logic   drag;
  } geom_t;

  // rectangle in wide signed arithmetic, nothing wraps
  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic   in_valid = 1'b0;
  logic   in_ready;
  logic [2:0] in_opcode = '0;
  coord_t in_win_x = '0;
  coord_t in_win_y = '0;
  size_t  in_win_w = '0;
  size_t  in_win_h = '0;
  coord_t in_pointer_x = '0;
  coord_t in_pointer_y = '0;

  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_x;
  coord_t out_y;
  coord_t out_w;
  coord_t out_h;
  logic [2:0] out_grab_edge;
  logic   out_ok;
  logic   out_drag_active;

  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  size_t  cfg_data = '0;

  // 10 ns clock
  always #5 clk = ~clk;

  window_resize_geometry_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_win_x        (in_win_x),
    .in_win_y        (in_win_y),
    .in_win_w        (in_win_w),
    .in_win_h        (in_win_h),
    .in_pointer_x    (in_pointer_x),
    .in_pointer_y    (in_pointer_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_w           (out_w),
    .out_h           (out_h),
    .out_grab_edge   (out_grab_edge),
    .out_ok          (out_ok),
    .out_drag_active (out_drag_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor state: register copies, drag and saved-rectangle state
  // ---------------------------------------------------------------------------
  size_t  reg_min_size;
  size_t  reg_header;
  size_t  reg_grab;
  size_t  reg_desk_w;
  size_t  reg_desk_h;

  logic   drag_on;
  box_t   grab_box;    // rectangle latched at begin
  box_t   goal_box;    // current drag target
  edge_t  grab_code;
  logic   saved_ok;
  box_t   saved_box;

  cmd_t   cmd_q[$];    // beats waiting for the driver
  geom_t  geom_q[$];   // predicted results, oldest first

  // bookkeeping
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_bad = 0;
  int unsigned n_begins = 0;
  int unsigned n_restored = 0;
  int unsigned n_settings = 0;

  // idling policy, changed per chunk by the stimulus thread
  logic        src_idle = 1'b1;
  logic        snk_idle = 1'b1;
  int unsigned src_gap = 0;
  int unsigned snk_stall = 0;
  logic        in_fired = 1'b0;

  cmd_t  drv_cmd;
  cmd_t  beat;
  geom_t got;
  geom_t want;

  function automatic box_t box_of(cmd_t c);
    box_t b;
    b.x = $signed(c.wx);
    b.y = $signed(c.wy);
    b.w = longint'(c.ww);
    b.h = longint'(c.wh);
    return b;
  endfunction

  // lower bound wins when the bounds cross
  function automatic longint clamp_lo_first(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the predictor by one accepted beat and return the result it causes
  function automatic geom_t resize_step(cmd_t c);
    longint px, py, hh, dw, dh, mn, g, w, h, x, y, fr, fb;
    logic   lf, rt, tp, bt;
    box_t   win, res;
    geom_t  r;
    px = $signed(c.px);
    py = $signed(c.py);
    hh = longint'(reg_header);
    dw = longint'(reg_desk_w);
    dh = longint'(reg_desk_h);
    mn = longint'(reg_min_size);
    g  = longint'(reg_grab);
    win = box_of(c);
    res = '{0, 0, 0, 0};
    r.ok = 1'b1;
    case (c.op)
      OP_BEGIN: begin
        drag_on  = 1'b1;
        grab_box = win;
        goal_box = win;
        res      = win;
        n_begins++;
        lf = px < win.x + g;
        rt = px >= win.x + win.w - g;
        tp = py < win.y + g;
        bt = py >= win.y + win.h + hh - g;
        // corners first, then single edges, then the default corner
        if (tp && lf)      grab_code = EDGE_TL;
        else if (tp && rt) grab_code = EDGE_TR;
        else if (bt && lf) grab_code = EDGE_BL;
        else if (bt && rt) grab_code = EDGE_BR;
        else if (lf)       grab_code = EDGE_L;
        else if (rt)       grab_code = EDGE_R;
        else if (tp)       grab_code = EDGE_T;
        else if (bt)       grab_code = EDGE_B;
        else               grab_code = EDGE_BR;
      end
      OP_UPDATE: begin
        if (drag_on) begin
          lf = grab_code inside {EDGE_L, EDGE_TL, EDGE_BL};
          rt = grab_code inside {EDGE_R, EDGE_TR, EDGE_BR};
          tp = grab_code inside {EDGE_T, EDGE_TL, EDGE_TR};
          bt = grab_code inside {EDGE_B, EDGE_BL, EDGE_BR};
          fr = grab_box.x + grab_box.w;
          fb = grab_box.y + grab_box.h + hh;
          w = grab_box.w;
          h = grab_box.h;
          x = grab_box.x;
          y = grab_box.y;
          if (rt) w = px - grab_box.x;
          if (lf) w = fr - px;
          if (bt) h = py - grab_box.y - hh;
          if (tp) h = fb - py - hh;
          // minimum first, so the desktop bound wins
          if (w < mn) w = mn;
          if (h < mn) h = mn;
          if (w > dw) w = dw;
          if (h > dh - hh) h = dh - hh;
          // left and top drags keep the opposite edge in place
          if (lf) x = fr - w;
          if (tp) y = fb - h - hh;
          goal_box.x = clamp_lo_first(x, 0, dw - w);
          goal_box.y = clamp_lo_first(y, 0, dh - h - hh);
          goal_box.w = w;
          goal_box.h = h;
          res = goal_box;
        end
      end
      OP_COMMIT: begin
        res = goal_box;
        drag_on = 1'b0;
      end
      OP_MAXIMIZE: begin
        saved_ok  = 1'b1;
        saved_box = win;
        res.w = dw;
        res.h = dh - hh;
      end
      OP_RESTORE: begin
        if (saved_ok) begin
          res = saved_box;
          saved_ok = 1'b0;
          n_restored++;
        end else begin
          r.ok = 1'b0;
        end
      end
      OP_CLEAR: saved_ok = 1'b0;
      default: ;
    endcase
    r.x = coord_t'(res.x);
    r.y = coord_t'(res.y);
    r.w = coord_t'(res.w);
    r.h = coord_t'(res.h);
    r.grab = grab_code;
    r.drag = drag_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic cmd_t mk(logic [2:0] op, int wx, int wy, int ww, int wh,
                              int px, int py);
    cmd_t c;
    c.op = op;
    c.wx = coord_t'(wx);
    c.wy = coord_t'(wy);
    c.ww = size_t'(ww);
    c.wh = size_t'(wh);
    c.px = coord_t'(px);
    c.py = coord_t'(py);
    return c;
  endfunction

  // pointer near the low border, near the high border, between, anywhere, or centered
  function automatic coord_t aim(longint lo, longint hi, longint s);
    case ($urandom_range(0, 4))
      0: return coord_t'(lo - s + longint'($urandom_range(0, int'(2 * s))));
      1: return coord_t'(hi - s + longint'($urandom_range(0, int'(2 * s))));
      2: return coord_t'(lo + longint'($urandom_range(0, hi > lo ? int'(hi - lo) : 0)));
      3: return coord_t'($urandom);
      default: return coord_t'(lo + (hi - lo) / 2);
    endcase
  endfunction

  // window sized to the desktop most of the time, any bit pattern now and then
  function automatic cmd_t rand_cmd(logic [2:0] op);
    cmd_t   c;
    box_t   b;
    longint g;
    g = longint'(reg_grab) + 1;
    c.op = op;
    if ($urandom_range(0, 7) == 0) begin
      c.wx = coord_t'($urandom);
      c.wy = coord_t'($urandom);
      c.ww = size_t'($urandom);
      c.wh = size_t'($urandom);
      c.px = coord_t'($urandom);
      c.py = coord_t'($urandom);
    end else begin
      c.wx = coord_t'($urandom_range(0, int'(reg_desk_w) + 64) - 64);
      c.wy = coord_t'($urandom_range(0, int'(reg_desk_h) + 64) - 64);
      c.ww = size_t'($urandom_range(0, int'(reg_desk_w)));
      c.wh = size_t'($urandom_range(0, int'(reg_desk_h)));
      b = box_of(c);
      c.px = aim(b.x, b.x + b.w, g);
      c.py = aim(b.y, b.y + b.h + longint'(reg_header), g);
    end
    return c;
  endfunction

  // mostly complete drags with random motion, the rest window commands and noise
  task automatic push_random(int unsigned n);
    int unsigned k;
    int unsigned r;
    longint      s;
    cmd_t        c;
    box_t        b;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        c = rand_cmd(OP_BEGIN);
        b = box_of(c);
        cmd_q.push_back(c);
        k++;
        // moves reach past the minimum size and past the desktop
        s = longint'(reg_min_size) + 64;
        repeat ($urandom_range(1, 6)) begin
          c = rand_cmd(OP_UPDATE);
          c.px = aim(b.x, b.x + b.w, s);
          c.py = aim(b.y, b.y + b.h + longint'(reg_header), s);
          cmd_q.push_back(c);
          k++;
        end
        if ($urandom_range(0, 99) < 85) begin
          cmd_q.push_back(rand_cmd(OP_COMMIT));
          k++;
        end
      end else begin
        if (r < 72)      c = rand_cmd(OP_MAXIMIZE);
        else if (r < 82) c = rand_cmd(OP_RESTORE);
        else if (r < 88) c = rand_cmd(OP_CLEAR);
        else if (r < 91) c = rand_cmd(OP_UPDATE);
        else if (r < 94) c = rand_cmd(OP_COMMIT);
        else             c = rand_cmd(3'($urandom_range(0, 7)));
        cmd_q.push_back(c);
        k++;
      end
    end
  endtask

  function automatic int unsigned pick_pause();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // wait until no beat is pending or in flight and every result is back, then let the bench idle
  task automatic wait_drained();
    do @(posedge clk); while (cmd_q.size() != 0 || in_valid || geom_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input size_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // register sets: extremes, crossed bounds, random and back to the usual desktop
  task automatic apply_setting(int unsigned k);
    size_t v[5];
    v = '{default: '0};
    case (k)
      1: v = '{default: '0};
      2: v = '{default: '1};
      3: begin
        v[0] = size_t'($urandom_range(1, 200));
        v[1] = size_t'($urandom_range(0, 60));
        v[2] = size_t'($urandom_range(0, 20));
        v[3] = size_t'($urandom_range(200, 4000));
        v[4] = size_t'($urandom_range(200, 3000));
      end
      4: v = '{size_t'(5000), size_t'(30), size_t'(10), size_t'(800), size_t'(600)};
      5: v = '{size_t'(16), size_t'(2000), size_t'(4), size_t'(1920), size_t'(1000)};
      6: foreach (v[i]) v[i] = size_t'($urandom);
      default: v = '{MIN_SIZE_RST, HEADER_H_RST, GRAB_ZONE_RST, DESK_W_RST, DESK_H_RST};
    endcase
    write_reg(CFG_MIN_SIZE, v[0]);
    write_reg(CFG_HEADER_H, v[1]);
    write_reg(CFG_GRAB_ZONE, v[2]);
    write_reg(CFG_DESK_W, v[3]);
    write_reg(CFG_DESK_H, v[4]);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: changes on the falling edge, holds a beat until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        drv_cmd = cmd_q.pop_front();
        in_opcode    <= drv_cmd.op;
        in_win_x     <= drv_cmd.wx;
        in_win_y     <= drv_cmd.wy;
        in_win_w     <= drv_cmd.ww;
        in_win_h     <= drv_cmd.wh;
        in_pointer_x <= drv_cmd.px;
        in_pointer_y <= drv_cmd.py;
        in_valid     <= 1'b1;
        // gap after this beat is taken
        src_gap = (src_idle && $urandom_range(0, 1) == 1) ? pick_pause() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls, mostly short
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (snk_stall > 0) begin
      snk_stall--;
      out_ready <= 1'b0;
    end else if (snk_idle && $urandom_range(0, 99) < 20) begin
      snk_stall = pick_pause() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: register writes, accepted beats and result checks on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fired = in_valid && in_ready;
    if (!rst_n) begin
      in_fired     = 1'b0;
      reg_min_size = MIN_SIZE_RST;
      reg_header   = HEADER_H_RST;
      reg_grab     = GRAB_ZONE_RST;
      reg_desk_w   = DESK_W_RST;
      reg_desk_h   = DESK_H_RST;
      drag_on      = 1'b0;
      grab_box     = '{0, 0, 0, 0};
      goal_box     = '{0, 0, 0, 0};
      saved_box    = '{0, 0, 0, 0};
      grab_code    = EDGE_L;
      saved_ok     = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_SIZE:  reg_min_size = cfg_data;
          CFG_HEADER_H:  reg_header   = cfg_data;
          CFG_GRAB_ZONE: reg_grab     = cfg_data;
          CFG_DESK_W:    reg_desk_w   = cfg_data;
          CFG_DESK_H:    reg_desk_h   = cfg_data;
          default: ;
        endcase
      end
      if (in_fired) begin
        beat = {in_opcode, in_win_x, in_win_y, in_win_w, in_win_h, in_pointer_x,
                in_pointer_y};
        geom_q.push_back(resize_step(beat));
        n_in++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        got.x    = out_x;
        got.y    = out_y;
        got.w    = out_w;
        got.h    = out_h;
        got.grab = edge_t'(out_grab_edge);
        got.ok   = out_ok;
        got.drag = out_drag_active;
        if (geom_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("result beat %0d arrived with nothing expected", n_out);
        end else begin
          want = geom_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("result beat %0d: want x=%0d y=%0d w=%0d h=%0d edge=%0d ok=%0b drag=%0b",
                       n_out, want.x, want.y, want.w, want.h, want.grab, want.ok, want.drag);
              $display("  got x=%0d y=%0d w=%0d h=%0d edge=%0d ok=%0b drag=%0b",
                       got.x, got.y, got.w, got.h, got.grab, got.ok, got.drag);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_items;
    int unsigned chunk;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset register values
    cmd_q.push_back(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0));          // nothing saved yet
    cmd_q.push_back(mk(OP_UPDATE, 5, 5, 50, 50, 20, 20));       // no drag: zeros
    cmd_q.push_back(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0));           // target still zero
    cmd_q.push_back(mk(OP_SPARE_6, -1, -1, 32767, 32767, -1, -1));
    cmd_q.push_back(mk(OP_SPARE_7, -32768, -32768, 0, 0, 32767, 32767));
    cmd_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_MAXIMIZE, -32768, 32767, 32767, 0, 0, 0));
    cmd_q.push_back(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0));          // saved rect comes back
    cmd_q.push_back(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0));          // only once
    cmd_q.push_back(mk(OP_MAXIMIZE, 10, 20, 300, 200, 0, 0));
    cmd_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0));          // cleared: not found
    cmd_q.push_back(mk(OP_BEGIN, 100, 100, 400, 300, 300, 250)); // no zone: bottom-right
    cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 32767, 32767));   // desktop clamp
    cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, -32768, -32768)); // minimum clamp
    cmd_q.push_back(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_BEGIN, 100, 100, 400, 300, 102, 200)); // left edge
    cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 600, 200));       // re-anchored at minimum
    cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, -32768, 200));    // wider than desktop
    cmd_q.push_back(mk(OP_BEGIN, 100, 100, 400, 300, 101, 101)); // begin again, top-left
    cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 50, 40));
    cmd_q.push_back(mk(OP_MAXIMIZE, 7, 9, 11, 13, 0, 0));       // drag left alone
    cmd_q.push_back(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0));           // no drag, stored target
    cmd_q.push_back(mk(OP_BEGIN, -32768, -32768, 0, 0, 32767, 32767));
    cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0));
    wait_drained();

    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k > 0) apply_setting(k);
      n_settings++;
      // minimum above the desktop: the desktop bound wins
      if (k == 4) begin
        cmd_q.push_back(mk(OP_BEGIN, 10, 10, 300, 200, 305, 230));
        cmd_q.push_back(mk(OP_UPDATE, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0));
      end
      // header taller than the desktop: negative maximized height
      if (k == 5) begin
        cmd_q.push_back(mk(OP_MAXIMIZE, 3, 4, 500, 400, 0, 0));
        cmd_q.push_back(mk(OP_RESTORE, 0, 0, 0, 0, 0, 0));
      end
      phase_items = 0;
      while (phase_items < 115) begin
        // some chunks run with no idling on one or both sides
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
        chunk = $urandom_range(20, 45);
        push_random(chunk);
        phase_items += chunk;
        // now and then the sender holds off until every result is back
        if ($urandom_range(0, 2) == 0) wait_drained();
        else do @(posedge clk); while (cmd_q.size() > 8);
      end
      wait_drained();
    end

    wait_drained();
    $display("covered %0d beats over %0d register sets: %0d drags begun, %0d restores hit",
             n_in, n_settings, n_begins, n_restored);
    $display("%0d result beats checked, %0d failures", n_out, n_bad);
    if (n_bad == 0 && geom_q.size() == 0) begin
      $display("[window_resize_geometry_top] OK");
    end else begin
      $display("[window_resize_geometry_top] ERROR");
    end
    $finish;
  end

  // hang guard, well past the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d results still expected", geom_q.size());
    $display("[window_resize_geometry_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/wrg_pkg.sv
design/window_resize_geometry_top.sv
tb/sv/window_resize_geometry_top_tb.sv
